### rtl/ktaf_pkg.sv
// ----------------------------------------------------------------------------
// ktaf_pkg
// Shared types, constants and helpers of the two-state tilt angle filter.
// ----------------------------------------------------------------------------
package ktaf_pkg;

	localparam int SigW    = 32;
	localparam int AngleW  = 25;
	localparam int RateW   = 28;
	localparam int CovFrac = 28;
	localparam int SumW    = 48;
	localparam int MulW    = 34;
	localparam int DenW    = 33;
	localparam int NumW    = 60;
	localparam int AddrW   = 4;

	// Register indexes
	localparam logic [1:0] REG_DT  = 2'd0;
	localparam logic [1:0] REG_QA  = 2'd1;
	localparam logic [1:0] REG_QB  = 2'd2;
	localparam logic [1:0] REG_R   = 2'd3;

	// Multiply steps of the sequencer
	localparam logic [3:0] OP_ANGLE_PRED = 4'd0;
	localparam logic [3:0] OP_P00_PRED   = 4'd1;
	localparam logic [3:0] OP_ROW_PRED   = 4'd2;
	localparam logic [3:0] OP_ANGLE_CORR = 4'd3;
	localparam logic [3:0] OP_BIAS_CORR  = 4'd4;
	localparam logic [3:0] OP_P00_UPD    = 4'd5;
	localparam logic [3:0] OP_P01_UPD    = 4'd6;
	localparam logic [3:0] OP_P10_UPD    = 4'd7;
	localparam logic [3:0] OP_P11_UPD    = 4'd8;

	localparam logic [28:0] DT_RESET = 29'd1342177;
	localparam logic [28:0] QA_RESET = 29'd268435;
	localparam logic [28:0] QB_RESET = 29'd805306;
	localparam logic [30:0] R_RESET  = 31'd134217728;
	localparam logic [31:0] COV_ONE  = 32'd268435456;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} ktaf_state_t;

	typedef struct packed {
		logic            go;
		logic [NumW-1:0] num;
		logic [DenW-1:0] den;
	} ktaf_div_req_t;

	typedef struct packed {
		logic            done;
		logic [DenW-1:0] quo;
		logic            ovf;
	} ktaf_div_rsp_t;

	// Sign extension of a 32-bit value to the sum width.
	function automatic logic signed [SumW-1:0] sx32(input logic [31:0] x);
		return {{(SumW-32){x[31]}}, x};
	endfunction

	// Saturation of a wide sum to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic signed [SumW-1:0] x);
		if (x > $signed({{(SumW-31){1'b0}}, {31{1'b1}}})) begin
			return 32'h7FFF_FFFF;
		end else if (x < $signed({{(SumW-31){1'b1}}, {31{1'b0}}})) begin
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

	// Product scaled back by the covariance fraction, ties toward +infinity.
	function automatic logic signed [SumW-1:0] qround(input logic signed [2*MulW-1:0] p);
		logic signed [2*MulW-1:0] t;
		t = p + $signed({{(2*MulW-CovFrac){1'b0}}, 1'b1, {(CovFrac-1){1'b0}}});
		return {{(SumW-(2*MulW-CovFrac)){t[2*MulW-1]}}, t[2*MulW-1:CovFrac]};
	endfunction

endpackage

### rtl/ktaf_if.sv
// ----------------------------------------------------------------------------
// ktaf_in_if / ktaf_out_if
// Valid/ready channels that carry the sensor items and the filtered items.
// ----------------------------------------------------------------------------
interface ktaf_in_if;
	logic               valid;
	logic               ready;
	logic signed [24:0] measured_angle;
	logic signed [27:0] measured_rate;

	modport source (output valid, measured_angle, measured_rate, input ready);
	modport sink   (input valid, measured_angle, measured_rate, output ready);
endinterface

interface ktaf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] angle_estimate;
	logic signed [31:0] rate_estimate;

	modport source (output valid, angle_estimate, rate_estimate, input ready);
	modport sink   (input valid, angle_estimate, rate_estimate, output ready);
endinterface

### rtl/kalman_tilt_angle_filter.sv
// ----------------------------------------------------------------------------
// kalman_tilt_angle_filter
// Two-state Kalman filter for tilt angle and gyro bias, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage: each input item carries an accelerometer angle in signed Q9.16 and a
// gyro rate in signed Q12.16. The block predicts the angle and the covariance,
// forms two gains by division and corrects the angle, the bias and the
// covariance, then sends one result item with the filtered angle and the
// bias-corrected rate. The work runs on one registered multiplier, nine
// products an item, and on a restoring divider of one bit per cycle that
// forms both gains one after the other; the division is skipped when the
// gain denominator is not positive. The input is not ready from an accepted
// item until its result is loaded into the output register, so the next
// item is taken only after that. A finished result waits in the output
// register while the next item is accepted; if the receiver still stalls
// when the next result is done, the sequencer holds.
// Reset clears the estimates, sets both variances to one and loads the
// default noise and time step settings. The APB port writes and reads the
// four settings; it should only be written while no item is in progress.
// ----------------------------------------------------------------------------
module kalman_tilt_angle_filter (
	input  logic                   clk,
	input  logic                   arst_n,
	ktaf_in_if.sink                in_ch,
	ktaf_out_if.source             out_ch,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ktaf_pkg::AddrW-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import ktaf_pkg::*;

	ktaf_state_t state_q;
	logic [3:0]  op_q;
	logic        ph_q;
	logic        div_sel_q;
	logic        div_neg_q;

	logic [28:0] dt_q, qa_q, qb_q;
	logic [30:0] r_q;

	logic [31:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic [31:0] a_q, b_q, c_q, d_q, k0_q, k1_q, err_q;
	logic [AngleW-1:0] z_q;
	logic [RateW-1:0]  rate_q;

	logic signed [MulW-1:0]     mul_a, mul_b;
	logic signed [2*MulW-1:0]   prod_q;
	logic signed [SumW-1:0]     rp;

	logic                  out_valid_q;
	logic [31:0]           out_angle_q, out_rate_q;

	logic                  div_go_q;
	logic [NumW-1:0]       div_num_q;
	logic [DenW-1:0]       div_den_q;
	ktaf_div_req_t         div_req;
	ktaf_div_rsp_t         div_rsp;

	logic signed [33:0]    e_sum;
	logic                  e_pos;
	logic [31:0]           c_mag, a_mag;
	logic signed [SumW-1:0] k_val;
	logic [31:0]           k_sat;
	logic [31:0]           rate_out;
	logic                  cfg_wr;

	assign div_req = {div_go_q, div_num_q, div_den_q};

	ktaf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RESET;
			qa_q <= QA_RESET;
			qb_q <= QB_RESET;
			r_q  <= R_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DT:  dt_q <= pwdata[28:0];
				REG_QA:  qa_q <= pwdata[28:0];
				REG_QB:  qb_q <= pwdata[28:0];
				REG_R:   r_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DT:  prdata = {3'b0, dt_q};
			REG_QA:  prdata = {3'b0, qa_q};
			REG_QB:  prdata = {3'b0, qb_q};
			REG_R:   prdata = {1'b0, r_q};
			default: prdata = '0;
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_ANGLE_PRED: begin
				mul_a = $signed({{(MulW-RateW){rate_q[RateW-1]}}, rate_q})
					- $signed({{(MulW-32){bias_q[31]}}, bias_q});
				mul_b = $signed({{(MulW-29){1'b0}}, dt_q});
			end
			OP_P00_PRED: begin
				mul_a = -($signed({{(MulW-32){p01_q[31]}}, p01_q})
					+ $signed({{(MulW-32){p10_q[31]}}, p10_q}));
				mul_b = $signed({{(MulW-29){1'b0}}, dt_q});
			end
			OP_ROW_PRED: begin
				mul_a = $signed({{(MulW-32){p11_q[31]}}, p11_q});
				mul_b = $signed({{(MulW-29){1'b0}}, dt_q});
			end
			OP_ANGLE_CORR: begin
				mul_a = $signed({{(MulW-32){k0_q[31]}}, k0_q});
				mul_b = $signed({{(MulW-32){err_q[31]}}, err_q});
			end
			OP_BIAS_CORR: begin
				mul_a = $signed({{(MulW-32){k1_q[31]}}, k1_q});
				mul_b = $signed({{(MulW-32){err_q[31]}}, err_q});
			end
			OP_P00_UPD: begin
				mul_a = $signed({{(MulW-32){k0_q[31]}}, k0_q});
				mul_b = $signed({{(MulW-32){a_q[31]}}, a_q});
			end
			OP_P01_UPD: begin
				mul_a = $signed({{(MulW-32){k0_q[31]}}, k0_q});
				mul_b = $signed({{(MulW-32){b_q[31]}}, b_q});
			end
			OP_P10_UPD: begin
				mul_a = $signed({{(MulW-32){k1_q[31]}}, k1_q});
				mul_b = $signed({{(MulW-32){a_q[31]}}, a_q});
			end
			OP_P11_UPD: begin
				mul_a = $signed({{(MulW-32){k1_q[31]}}, k1_q});
				mul_b = $signed({{(MulW-32){b_q[31]}}, b_q});
			end
			default: ;
		endcase
	end

	assign rp = qround(prod_q);

	// Gain denominator and numerator magnitudes.
	assign e_sum = $signed({3'b0, r_q}) + $signed({{2{a_q[31]}}, a_q});
	assign e_pos = !e_sum[33] && (e_sum != '0);
	assign a_mag = a_q[31] ? 32'(-a_q) : a_q;
	assign c_mag = c_q[31] ? 32'(-c_q) : c_q;

	// Signed gain from the divider result, saturated.
	always_comb begin
		k_val = div_neg_q ? -$signed({{(SumW-DenW){1'b0}}, div_rsp.quo})
			: $signed({{(SumW-DenW){1'b0}}, div_rsp.quo});
		if (div_rsp.ovf) begin
			k_sat = div_neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			k_sat = sat32(k_val);
		end
	end

	assign rate_out = sat32($signed({{(SumW-RateW){rate_q[RateW-1]}}, rate_q}) - sx32(bias_q));

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ANGLE_PRED;
			ph_q        <= 1'b0;
			div_sel_q   <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A division starts after the row prediction when the gain denominator is positive, and again after the first gain.
			div_go_q <= (state_q == S_MUL && ph_q && op_q == OP_ROW_PRED && e_pos)
				|| (state_q == S_DIV && div_rsp.done && !div_sel_q);
			if (out_ch.valid && out_ch.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_MUL;
						op_q    <= OP_ANGLE_PRED;
						ph_q    <= 1'b0;
					end
				end
				S_MUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (op_q == OP_ROW_PRED) begin
							if (e_pos) begin
								state_q   <= S_DIV;
								div_sel_q <= 1'b0;
							end
							op_q <= OP_ANGLE_CORR;
						end else if (op_q == OP_P11_UPD) begin
							state_q <= S_OUT;
						end else begin
							op_q <= op_q + 4'd1;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (!div_sel_q) begin
							div_sel_q <= 1'b1;
						end else begin
							state_q <= S_MUL;
							ph_q    <= 1'b0;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Filter state: estimates and covariance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q  <= '0;
			p00_q   <= COV_ONE;
			p01_q   <= '0;
			p10_q   <= '0;
			p11_q   <= COV_ONE;
		end else if (state_q == S_MUL && ph_q) begin
			case (op_q)
				OP_ANGLE_PRED: angle_q <= sat32(sx32(angle_q) + rp);
				OP_ANGLE_CORR: angle_q <= sat32(sx32(angle_q) + rp);
				OP_BIAS_CORR:  bias_q  <= sat32(sx32(bias_q) + rp);
				OP_P00_UPD:    p00_q   <= sat32(sx32(a_q) - rp);
				OP_P01_UPD:    p01_q   <= sat32(sx32(b_q) - rp);
				OP_P10_UPD:    p10_q   <= sat32(sx32(c_q) - rp);
				OP_P11_UPD:    p11_q   <= sat32(sx32(d_q) - rp);
				default: ;
			endcase
		end
	end

	// Working registers: input item, product, predicted row, gains, divider operands and result.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			z_q    <= in_ch.measured_angle;
			rate_q <= in_ch.measured_rate;
		end
		if (state_q == S_MUL && !ph_q) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == S_MUL && ph_q) begin
			case (op_q)
				OP_P00_PRED: begin
					a_q   <= sat32(sx32(p00_q) + rp + $signed({{(SumW-29){1'b0}}, qa_q}));
					err_q <= sat32($signed({{(SumW-AngleW){z_q[AngleW-1]}}, z_q})
						- sx32(angle_q));
				end
				OP_ROW_PRED: begin
					b_q       <= sat32(sx32(p01_q) - rp);
					c_q       <= sat32(sx32(p10_q) - rp);
					d_q       <= sat32(sx32(p11_q) + $signed({{(SumW-29){1'b0}}, qb_q}));
					k0_q      <= '0;
					k1_q      <= '0;
					div_num_q <= {a_mag, {CovFrac{1'b0}}};
					div_den_q <= e_sum[DenW-1:0];
					div_neg_q <= a_q[31];
				end
				default: ;
			endcase
		end
		if (state_q == S_DIV && div_rsp.done) begin
			if (!div_sel_q) begin
				k0_q      <= k_sat;
				div_num_q <= {c_mag, {CovFrac{1'b0}}};
				div_neg_q <= c_q[31];
			end else begin
				k1_q <= k_sat;
			end
		end
		if (state_q == S_OUT && (!out_valid_q || out_ch.ready)) begin
			out_angle_q <= angle_q;
			out_rate_q  <= rate_out;
		end
	end

	assign in_ch.ready           = (state_q == S_IDLE);
	assign out_ch.valid          = out_valid_q;
	assign out_ch.angle_estimate = out_angle_q;
	assign out_ch.rate_estimate  = out_rate_q;

	// A gain result only arrives while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the gain phase");

	// An accepted item always starts with the angle prediction.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q == S_MUL && op_q == OP_ANGLE_PRED && !ph_q))
		else $error("item accepted without a fresh sequence");

	// The step counter never runs past the last covariance update.
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		op_q <= OP_P11_UPD)
		else $error("step counter out of range");

	// A new result is loaded only from the output state.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the output state");

endmodule

### rtl/ktaf_div.sv
// ----------------------------------------------------------------------------
// ktaf_div
// Restoring divider, one quotient bit per cycle, for the filter gains.
// ----------------------------------------------------------------------------
module ktaf_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ktaf_pkg::ktaf_div_req_t req,
	output ktaf_pkg::ktaf_div_rsp_t rsp
);
	import ktaf_pkg::*;

	localparam int TopW = NumW - DenW;

	logic            busy_q;
	logic [5:0]      cnt_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] sh_q;
	logic [DenW-1:0] den_q;
	logic            ovf_q;
	logic            done_q;
	logic [DenW:0]   trial;
	logic            ge;

	// One trial subtraction per cycle.
	assign trial = {rem_q[DenW-1:0], sh_q[DenW-1]};
	assign ge    = trial >= {1'b0, den_q};

	// Control: busy flag, bit counter and done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DenW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: flags overflow at start; if none, rem stays below the divisor.
	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= {{(DenW+1-TopW){1'b0}}, req.num[NumW-1:DenW]};
			sh_q  <= req.num[DenW-1:0];
			den_q <= req.den;
			ovf_q <= {{(DenW-TopW){1'b0}}, req.num[NumW-1:DenW]} >= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			sh_q  <= {sh_q[DenW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sh_q;
	assign rsp.ovf  = ovf_q;

endmodule
